// ===== rtl/vvuq_pkg.sv =====
// Shared constants, codes and types for the VRAM update queue.
package vvuq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int FIFO_DEPTH  = 2;
    localparam int FPTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FLVL_W      = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W   = 1;

    localparam logic [15:0] WIN_LOW_RESET  = 16'h8000;
    localparam logic [15:0] WIN_HIGH_RESET = 16'hBFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HIGH = 1'b1;

    localparam logic [2:0] MODE_COPY      = 3'd0;
    localparam logic [2:0] MODE_FILL      = 3'd1;
    localparam logic [2:0] MODE_FLUSH     = 3'd2;
    localparam logic [2:0] MODE_CLEAR     = 3'd3;
    localparam logic [2:0] MODE_CLR_DROPS = 3'd4;
    localparam logic [2:0] MODE_TICK      = 3'd5;

    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_COPY = 1'b1;

    typedef enum logic [2:0] {
        OP_ENQ_COPY,
        OP_ENQ_FILL,
        OP_FLUSH,
        OP_CLEAR,
        OP_CLR_DROPS,
        OP_TICK,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        req_ok;
        logic [15:0] dst;
        logic [23:0] src;
        logic [15:0] val;
        logic [15:0] len;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] dest;
        logic [15:0] len;
        logic [23:0] src;
        logic [15:0] val;
    } entry_t;

    typedef struct packed {
        logic             accepted;
        logic             write_valid;
        logic             write_kind;
        logic [15:0]      write_addr;
        logic [23:0]      read_addr;
        logic [15:0]      write_value;
        logic             last;
        logic [CNT_W-1:0] pending;
        logic [7:0]       dropped;
        logic             draining;
    } res_t;

endpackage

// ===== rtl/vvuq_if.sv =====
// Channel interfaces: command words in, result words out, register writes.
interface vvuq_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] dst_addr;
    logic [23:0] src_addr;
    logic [15:0] fill_value;
    logic [15:0] word_count;

    modport source (output valid, mode, dst_addr, src_addr, fill_value, word_count,
                    input ready);
    modport sink   (input valid, mode, dst_addr, src_addr, fill_value, word_count,
                    output ready);
endinterface

interface vvuq_res_if;
    import vvuq_pkg::*;
    logic             valid;
    logic             ready;
    logic             accepted;
    logic             write_valid;
    logic             write_kind;
    logic [15:0]      write_addr;
    logic [23:0]      read_addr;
    logic [15:0]      write_value;
    logic             last;
    logic [CNT_W-1:0] pending;
    logic [7:0]       dropped;
    logic             draining;

    modport source (output valid, accepted, write_valid, write_kind, write_addr, read_addr,
                    write_value, last, pending, dropped, draining,
                    input ready);
    modport sink   (input valid, accepted, write_valid, write_kind, write_addr, read_addr,
                    write_value, last, pending, dropped, draining,
                    output ready);
endinterface

interface vvuq_cfg_if;
    import vvuq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/vblank_vram_update_queue.sv =====
// Top level of the deferred VRAM write-command queue.
// Every command word yields exactly one result word. The front end checks the
// destination window against the window registers and pushes the classified word into
// a two-word queue; the back end executes one word per cycle against a 16-entry command
// store and registers the result, so the block sustains one word per clock when the
// result side keeps up; a word passes the queue and the result register. During a flush
// each tick emits one video-memory word write; the flush ends on the write flagged last.
// Window registers are written through the config channel, which is always ready, and
// should be changed only while the block is idle.
module vblank_vram_update_queue (
    input  logic       clk,
    input  logic       rst_n,
    vvuq_cmd_if.sink   cmd,
    vvuq_cfg_if.sink   cfg,
    vvuq_res_if.source res
);
    import vvuq_pkg::*;

    head_t head;
    logic  pop;

    vvuq_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .cfg   (cfg),
        .head  (head),
        .pop   (pop)
    );

    vvuq_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

    a_last_ends_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.last) |-> (res.write_valid && !res.draining
                                     && (res.pending == '0)))
        else $error("last write does not close the flush");

    a_write_is_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.write_valid) |-> res.accepted)
        else $error("write emitted by a refused word");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.write_valid) |-> ((res.write_addr == 16'd0)
                                             && (res.read_addr == 24'd0) && !res.last))
        else $error("write fields set without a write");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.pending <= CNT_W'(QUEUE_DEPTH)))
        else $error("pending count exceeds queue depth");

    a_pop_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("back end popped an empty queue");

endmodule

// ===== rtl/vvuq_front.sv =====
// Front end: window registers, request classification and the command queue.
module vvuq_front (
    input  logic            clk,
    input  logic            rst_n,
    vvuq_cmd_if.sink        cmd,
    vvuq_cfg_if.sink        cfg,
    output vvuq_pkg::head_t head,
    input  logic            pop
);
    import vvuq_pkg::*;

    logic [15:0]       win_low_reg;
    logic [15:0]       win_high_reg;
    cmd_t              fifo_mem_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg;
    logic [FPTR_W-1:0] rd_ptr_reg;
    logic [FLVL_W-1:0] level_reg;
    logic [FPTR_W-1:0] wr_ptr_next;
    logic [FPTR_W-1:0] rd_ptr_next;
    logic [FLVL_W-1:0] level_next;
    cmd_t              cls;
    logic [17:0]       win_end;
    logic              win_ok;
    logic              push;
    logic              do_pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_low_reg  <= WIN_LOW_RESET;
            win_high_reg <= WIN_HIGH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_WIN_LOW:  win_low_reg  <= cfg.data;
                CFG_WIN_HIGH: win_high_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Last byte of the destination window; wraps at 18 bits only when address and count are zero.
    assign win_end = {2'b00, cmd.dst_addr} + {1'b0, cmd.word_count, 1'b0} - 18'd1;
    assign win_ok  = (cmd.dst_addr != 16'd0) && (cmd.word_count != 16'd0)
                     && (cmd.dst_addr >= win_low_reg)
                     && (win_end <= {2'b00, win_high_reg});

    always_comb
    begin
        cls.dst    = cmd.dst_addr;
        cls.src    = cmd.src_addr;
        cls.val    = cmd.fill_value;
        cls.len    = cmd.word_count;
        cls.req_ok = 1'b0;
        case (cmd.mode)
            MODE_COPY:
            begin
                cls.op     = OP_ENQ_COPY;
                cls.req_ok = win_ok && (cmd.src_addr != 24'd0);
            end
            MODE_FILL:
            begin
                cls.op     = OP_ENQ_FILL;
                cls.req_ok = win_ok;
            end
            MODE_FLUSH:     cls.op = OP_FLUSH;
            MODE_CLEAR:     cls.op = OP_CLEAR;
            MODE_CLR_DROPS: cls.op = OP_CLR_DROPS;
            MODE_TICK:      cls.op = OP_TICK;
            default:        cls.op = OP_NOP;
        endcase
    end

    assign cmd.ready = (level_reg != FLVL_W'(FIFO_DEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign do_pop    = pop && (level_reg != '0);

    assign head.valid = (level_reg != '0);
    assign head.cmd   = fifo_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0
                          : wr_ptr_reg + FPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0
                          : rd_ptr_reg + FPTR_W'(1);
        end
        if (push && !do_pop)
        begin
            level_next = level_reg + FLVL_W'(1);
        end
        else if (do_pop && !push)
        begin
            level_next = level_reg - FLVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/vvuq_back.sv =====
// Back end: entry store, drain sequencer, counters and the result register.
module vvuq_back (
    input  logic            clk,
    input  logic            rst_n,
    input  vvuq_pkg::head_t head,
    output logic            pop,
    vvuq_res_if.source      res
);
    import vvuq_pkg::*;

    entry_t           entry_mem [QUEUE_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       drop_reg;
    logic             drain_reg;
    logic [IDX_W-1:0] didx_reg;
    logic [15:0]      woff_reg;
    logic             out_valid_reg;
    res_t             out_reg;
    entry_t           ent_reg;

    logic [CNT_W-1:0] count_next;
    logic [7:0]       drop_next;
    logic             drain_next;
    logic [IDX_W-1:0] didx_next;
    logic [15:0]      woff_next;
    res_t             res_next;

    cmd_t             cur;
    entry_t           ent_wdata;
    logic             ent_we;
    logic             issue;
    logic [15:0]      woff_inc;
    logic [CNT_W-1:0] idx_inc;

    assign cur      = head.cmd;
    assign issue    = head.valid && (!out_valid_reg || res.ready);
    assign pop      = issue;
    assign woff_inc = woff_reg + 16'd1;
    assign idx_inc  = CNT_W'(didx_reg) + CNT_W'(1);

    always_comb
    begin
        ent_wdata.kind = (cur.op == OP_ENQ_COPY) ? KIND_COPY : KIND_FILL;
        ent_wdata.dest = cur.dst;
        ent_wdata.len  = cur.len;
        ent_wdata.src  = cur.src;
        ent_wdata.val  = cur.val;
    end

    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        drain_next = drain_reg;
        didx_next  = didx_reg;
        woff_next  = woff_reg;
        res_next   = '0;
        ent_we     = 1'b0;
        if (issue)
        begin
            case (cur.op)
                OP_ENQ_COPY, OP_ENQ_FILL:
                begin
                    if (!drain_reg && cur.req_ok)
                    begin
                        if (count_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            drop_next = drop_reg + 8'd1;
                        end
                        else
                        begin
                            ent_we            = 1'b1;
                            count_next        = count_reg + CNT_W'(1);
                            res_next.accepted = 1'b1;
                        end
                    end
                end
                OP_FLUSH:
                begin
                    if (!drain_reg && (count_reg != '0))
                    begin
                        drain_next        = 1'b1;
                        didx_next         = '0;
                        woff_next         = '0;
                        res_next.accepted = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    if (!drain_reg)
                    begin
                        count_next        = '0;
                        res_next.accepted = 1'b1;
                    end
                end
                OP_CLR_DROPS:
                begin
                    drop_next         = '0;
                    res_next.accepted = 1'b1;
                end
                OP_TICK:
                begin
                    if (drain_reg)
                    begin
                        res_next.accepted    = 1'b1;
                        res_next.write_valid = 1'b1;
                        res_next.write_kind  = ent_reg.kind;
                        res_next.write_addr  = ent_reg.dest + {woff_reg[14:0], 1'b0};
                        if (ent_reg.kind == KIND_COPY)
                        begin
                            res_next.read_addr = ent_reg.src + {7'd0, woff_reg, 1'b0};
                        end
                        else
                        begin
                            res_next.write_value = ent_reg.val;
                        end
                        woff_next = woff_inc;
                        // Advance to the next entry, or end the flush after the last one.
                        if (woff_inc >= ent_reg.len)
                        begin
                            woff_next = '0;
                            if (idx_inc >= count_reg)
                            begin
                                drain_next    = 1'b0;
                                didx_next     = '0;
                                count_next    = '0;
                                res_next.last = 1'b1;
                            end
                            else
                            begin
                                didx_next = idx_inc[IDX_W-1:0];
                            end
                        end
                    end
                end
                default: ;
            endcase
            res_next.pending  = count_next;
            res_next.dropped  = drop_next;
            res_next.draining = drain_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drop_reg      <= '0;
            drain_reg     <= 1'b0;
            didx_reg      <= '0;
            woff_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
            drain_reg <= drain_next;
            didx_reg  <= didx_next;
            woff_reg  <= woff_next;
            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the entry at the next drain index; the store is never written while draining,
    // and the flush word itself reloads it after the last enqueue.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            out_reg <= res_next;
        end
        if (ent_we)
        begin
            entry_mem[count_reg[IDX_W-1:0]] <= ent_wdata;
        end
        ent_reg <= entry_mem[didx_next];
    end

    assign res.valid       = out_valid_reg;
    assign res.accepted    = out_reg.accepted;
    assign res.write_valid = out_reg.write_valid;
    assign res.write_kind  = out_reg.write_kind;
    assign res.write_addr  = out_reg.write_addr;
    assign res.read_addr   = out_reg.read_addr;
    assign res.write_value = out_reg.write_value;
    assign res.last        = out_reg.last;
    assign res.pending     = out_reg.pending;
    assign res.dropped     = out_reg.dropped;
    assign res.draining    = out_reg.draining;

endmodule
